FILE: sv/tkpc_pkg.sv
// shared types and constants for the touch key press classifier
`default_nettype none

package tkpc_pkg;

  localparam int CAL_SAMPLES_DEF = 10;
  localparam int CAL_DISCARD_DEF = 5;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int BASE_W    = 10;
  localparam int OFFSET_W  = 8;
  localparam int TIMEOUT_W = 16;
  localparam int ELAPSED_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [BASE_W-1:0]    BASE_MAX      = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [BASE_W-1:0]    BASE_RST      = 10'd0;
  localparam logic [OFFSET_W-1:0]  UPPER_RST     = 8'd30;
  localparam logic [OFFSET_W-1:0]  LOWER_RST     = 8'd15;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd1000;
  localparam logic                 AUTO_CAL_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_THRESHOLD  = 3'd0,
    REG_UPPER_OFFSET    = 3'd1,
    REG_LOWER_OFFSET    = 3'd2,
    REG_LONG_TIMEOUT_MS = 3'd3,
    REG_AUTO_CALIBRATE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } press_status_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  typedef struct packed {
    press_status_t status;
    logic          edge_start;
    logic          level;
    logic          cal;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/touch_key_press_classifier_core.sv
// touch key press classifier: top level with state update and output buffering
//
// One word is taken per cycle while in_stall is low, and its result leaves from an output
// register; a second result register absorbs one word while the output is stalled, so
// in_stall rises only when both hold results. Sample and tick words update the press
// state as each is accepted. With auto calibration on, the first CAL_SAMPLES sample words
// after reset feed the calibration window and report calibrating; the base is the mean
// of window samples CAL_DISCARD and later, formed by a constant reciprocal multiply.
// Configuration writes are always ready and take effect at the next word.
`default_nettype none

module touch_key_press_classifier_core
  import tkpc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
  parameter int CAL_DISCARD = CAL_DISCARD_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   req_type,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  press_status,
  output logic                        press_edge,
  output logic                        level_pressed,
  output logic                        calibrating,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DAT_W-1:0]   cfg_data
);

  localparam bit CAL_ON   = CAL_SAMPLES > CAL_DISCARD;
  localparam int CAL_DIV  = CAL_ON ? (CAL_SAMPLES - CAL_DISCARD) : 1;
  localparam int CAL_LOG  = $clog2(CAL_DIV);
  localparam int SUM_W    = SAMPLE_BITS + CAL_LOG;
  localparam int CAL_SHIFT = SUM_W + CAL_LOG;
  localparam int PROD_W   = 2 * SUM_W + CAL_LOG + 1;
  localparam longint CAL_MUL_L = ((64'd1 << CAL_SHIFT) + CAL_DIV - 1) / CAL_DIV;
  localparam logic [SUM_W:0] CAL_MUL = CAL_MUL_L[SUM_W:0];
  localparam int AVG_W    = (SUM_W > BASE_W) ? SUM_W : BASE_W;
  localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] DISC_LIM =
    CNT_W'(CAL_ON ? CAL_DISCARD : CAL_SAMPLES);
  localparam int CMP_W    = (SAMPLE_BITS > BASE_W + 1) ? SAMPLE_BITS : BASE_W + 1;

  // configuration registers
  logic [BASE_W-1:0]    base_threshold;
  logic [OFFSET_W-1:0]  upper_offset;
  logic [OFFSET_W-1:0]  lower_offset;
  logic [TIMEOUT_W-1:0] long_timeout_ms;
  logic                 auto_calibrate;

  // press state
  logic                 finger_held, finger_held_next;
  logic                 timing_active, timing_active_next;
  logic [ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [CNT_W-1:0]     cal_count, cal_count_next;
  logic [SUM_W-1:0]     cal_sum, cal_sum_next;

  // output buffering
  res_t out_res, skid_res, new_res;
  logic skid_valid;

  logic                 accept, drain;
  logic                 window_open;
  logic [PROD_W-1:0]    cal_prod;
  logic [AVG_W-1:0]     cal_avg;
  logic [BASE_W-1:0]    active_base;
  logic [BASE_W-1:0]    base;
  logic [CMP_W-1:0]     upper, lower, samp;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 held;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign drain     = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  assign press_status  = out_res.status;
  assign press_edge    = out_res.edge_start;
  assign level_pressed = out_res.level;
  assign calibrating   = out_res.cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_threshold  <= BASE_RST;
      upper_offset    <= UPPER_RST;
      lower_offset    <= LOWER_RST;
      long_timeout_ms <= TIMEOUT_RST;
      auto_calibrate  <= AUTO_CAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_THRESHOLD:  base_threshold  <= cfg_data[BASE_W-1:0];
        REG_UPPER_OFFSET:    upper_offset    <= cfg_data[OFFSET_W-1:0];
        REG_LOWER_OFFSET:    lower_offset    <= cfg_data[OFFSET_W-1:0];
        REG_LONG_TIMEOUT_MS: long_timeout_ms <= cfg_data[TIMEOUT_W-1:0];
        REG_AUTO_CALIBRATE:  auto_calibrate  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // window mean from the finished sum, exact for every sum below 2^SUM_W
  assign cal_prod = PROD_W'(cal_sum) * PROD_W'(CAL_MUL);
  assign cal_avg  = AVG_W'(cal_prod[CAL_SHIFT +: SUM_W]);

  always_comb begin
    if (!CAL_ON) begin
      active_base = '0;
    end else if (cal_avg > AVG_W'(BASE_MAX)) begin
      active_base = BASE_MAX;
    end else begin
      active_base = cal_avg[BASE_W-1:0];
    end
  end

  assign window_open = auto_calibrate && (cal_count < CNT_LIM);
  assign base        = auto_calibrate ? active_base : base_threshold;
  assign upper       = CMP_W'({1'b0, base}) + CMP_W'(upper_offset);
  assign lower       = CMP_W'({1'b0, base}) + CMP_W'(lower_offset);
  assign samp        = CMP_W'(sample);
  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;

  always_comb begin
    finger_held_next   = finger_held;
    timing_active_next = timing_active;
    elapsed_ms_next    = elapsed_ms;
    cal_count_next     = cal_count;
    cal_sum_next       = cal_sum;
    new_res            = '{status: ST_IDLE, edge_start: 1'b0, level: 1'b0, cal: 1'b0};
    held               = finger_held && !(samp < lower);
    if (accept) begin
      if (req_type == REQ_TICK) begin
        if (timing_active) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc > ELAPSED_W'(long_timeout_ms)) begin
            new_res.status     = ST_LONG;
            timing_active_next = 1'b0;
          end
        end
        new_res.cal = window_open;
      end else if (window_open) begin
        if (cal_count >= DISC_LIM) begin
          cal_sum_next = cal_sum + SUM_W'(sample);
        end
        cal_count_next = cal_count + 1'b1;
        new_res.cal    = 1'b1;
      end else begin
        new_res.level = samp > upper;
        if (timing_active) begin
          if (samp < lower) begin
            new_res.status     = (ELAPSED_W'(long_timeout_ms) > elapsed_ms) ?
                                 ST_SHORT : ST_LONG;
            timing_active_next = 1'b0;
            finger_held_next   = 1'b0;
          end
        end else begin
          finger_held_next = held;
          if (samp > upper && !held) begin
            finger_held_next   = 1'b1;
            timing_active_next = 1'b1;
            elapsed_ms_next    = '0;
            new_res.edge_start = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_held   <= 1'b0;
      timing_active <= 1'b0;
      elapsed_ms    <= '0;
      cal_count     <= '0;
      cal_sum       <= '0;
    end else begin
      finger_held   <= finger_held_next;
      timing_active <= timing_active_next;
      elapsed_ms    <= elapsed_ms_next;
      cal_count     <= cal_count_next;
      cal_sum       <= cal_sum_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || drain) begin
      out_valid <= accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || drain) begin
      if (accept) begin
        out_res <= new_res;
      end
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_timing_needs_finger: assert property (@(posedge clk) disable iff (rst)
    timing_active |-> finger_held)
    else $error("timing active without a held finger");

  a_press_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(timing_active) |-> elapsed_ms == '0)
    else $error("press started with nonzero elapsed time");

  a_edge_has_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_edge |-> press_status == ST_IDLE && !calibrating && level_pressed)
    else $error("press edge word carries inconsistent fields");

  a_cal_count_bound: assert property (@(posedge clk) disable iff (rst)
    cal_count <= CNT_LIM)
    else $error("calibration count past window length");
`endif

endmodule

`default_nettype wire

FILE: tb/tkpc_checker.sv
// result predictor and checker for the touch key press classifier
module tkpc_checker
  import tkpc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic                       req_type,
  input  wire logic [SAMPLE_BITS_DEF-1:0] sample,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [1:0]                 press_status,
  input  wire logic                       press_edge,
  input  wire logic                       level_pressed,
  input  wire logic                       calibrating,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DAT_W-1:0]       cfg_data,
  output int                              failures,
  output int                              outstanding
);

  localparam int WINDOW_LEN = CAL_SAMPLES_DEF - CAL_DISCARD_DEF;

  logic [BASE_W-1:0]    base_reg;
  logic [OFFSET_W-1:0]  upper_reg;
  logic [OFFSET_W-1:0]  lower_reg;
  logic [TIMEOUT_W-1:0] timeout_reg;
  logic                 autocal_reg;

  logic                 held;
  logic                 timing;
  logic [ELAPSED_W-1:0] elapsed;
  logic [3:0]           win_count;
  logic [12:0]          win_sum;
  logic [BASE_W-1:0]    cal_base;

  res_t expected_q[$];
  int   fail_cnt = 0;
  int   reported = 0;

  function automatic res_t classify_word(input logic kind,
                                         input logic [SAMPLE_BITS_DEF-1:0] value);
    res_t              r;
    logic              win_open;
    logic [BASE_W-1:0] base;
    logic [BASE_W:0]   upper;
    logic [BASE_W:0]   lower;
    logic [12:0]       avg;
    r = '0;
    win_open = autocal_reg && (win_count < CAL_SAMPLES_DEF);
    if (kind == REQ_TICK) begin
      if (timing) begin
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (elapsed > {1'b0, timeout_reg}) begin
          r.status = ST_LONG;
          timing = 1'b0;
        end
      end
      r.cal = win_open;
    end else if (win_open) begin
      if (win_count >= CAL_DISCARD_DEF) win_sum = win_sum + value;
      win_count = win_count + 1'b1;
      if (win_count >= CAL_SAMPLES_DEF) begin
        avg = win_sum / WINDOW_LEN;
        cal_base = (avg > BASE_MAX) ? BASE_MAX : avg[BASE_W-1:0];
      end
      r.cal = 1'b1;
    end else begin
      base = autocal_reg ? cal_base : base_reg;
      upper = base + upper_reg;
      lower = base + lower_reg;
      r.level = ({1'b0, value} > upper);
      if (timing) begin
        if ({1'b0, value} < lower) begin
          r.status = (elapsed < {1'b0, timeout_reg}) ? ST_SHORT : ST_LONG;
          timing = 1'b0;
          held = 1'b0;
        end
      end else begin
        if ({1'b0, value} < lower) held = 1'b0;
        if ({1'b0, value} > upper && !held) begin
          held = 1'b1;
          timing = 1'b1;
          elapsed = '0;
          r.edge_start = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      base_reg = BASE_RST;
      upper_reg = UPPER_RST;
      lower_reg = LOWER_RST;
      timeout_reg = TIMEOUT_RST;
      autocal_reg = AUTO_CAL_RST;
      held = 1'b0;
      timing = 1'b0;
      elapsed = '0;
      win_count = '0;
      win_sum = '0;
      cal_base = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_THRESHOLD:  base_reg = cfg_data[BASE_W-1:0];
          REG_UPPER_OFFSET:    upper_reg = cfg_data[OFFSET_W-1:0];
          REG_LOWER_OFFSET:    lower_reg = cfg_data[OFFSET_W-1:0];
          REG_LONG_TIMEOUT_MS: timeout_reg = cfg_data[TIMEOUT_W-1:0];
          REG_AUTO_CALIBRATE:  autocal_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(classify_word(req_type, sample));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (reported < 10)
            $display("unexpected result word: status %0d edge %0b level %0b cal %0b",
                     press_status, press_edge, level_pressed, calibrating);
          reported++;
        end else begin
          want = expected_q.pop_front();
          if (press_status !== want.status || press_edge !== want.edge_start ||
              level_pressed !== want.level || calibrating !== want.cal) begin
            fail_cnt++;
            if (reported < 10)
              $display(
                "mismatch %0t exp/got: status %0d/%0d edge %0b/%0b level %0b/%0b cal %0b/%0b",
                $realtime, want.status, press_status, want.edge_start, press_edge,
                want.level, level_pressed, want.cal, calibrating);
            reported++;
          end
        end
      end
    end
    failures <= fail_cnt;
    outstanding <= expected_q.size();
  end

endmodule

FILE: tb/tb.sv
// top-level testbench: stimulus, stall patterns and verdict for the press classifier
module tb
  import tkpc_pkg::*;
();

  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int OFFSET_MAX  = (1 << OFFSET_W) - 1;
  localparam int CAL_BASE    = 200;
  localparam int STALL_LIMIT = 1000;
  localparam int WORD_TARGET = 950;
  localparam int STEADY_FROM = 800;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       req_type;
  logic [SAMPLE_BITS_DEF-1:0] sample;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 press_status;
  logic                       press_edge;
  logic                       level_pressed;
  logic                       calibrating;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DAT_W-1:0]       cfg_data;

  int failures;
  int outstanding;
  int words_sent = 0;
  int dead_cycles = 0;
  int cur_upper;
  int cur_lower;
  int cur_timeout;
  int phase;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit holding = 1'b0;

  touch_key_press_classifier_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .press_status(press_status),
    .press_edge(press_edge), .level_pressed(level_pressed), .calibrating(calibrating),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tkpc_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .press_status(press_status),
    .press_edge(press_edge), .level_pressed(level_pressed), .calibrating(calibrating),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("touch_key_press_classifier_core test failed");
      $finish;
    end
  end

  // result side stall pattern
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        holding <= 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
        out_stall <= 1'b0;
        holding <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input req_type_t kind, input logic [SAMPLE_BITS_DEF-1:0] value);
    if (!steady && !holding && !(hold_req && !hold_done) && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (words_sent == STEADY_FROM) steady <= 1'b1;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // drain every pending result before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick(input int lo, input int hi);
    int a;
    int b;
    a = (lo < 0) ? 0 : lo;
    b = (hi > SAMPLE_MAX) ? SAMPLE_MAX : hi;
    if (a > b) return SAMPLE_BITS_DEF'($urandom);
    return SAMPLE_BITS_DEF'($urandom_range(a, b));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] with_junk(input int value, input int width);
    return CFG_DAT_W'(($urandom & ~((32'd1 << width) - 1)) | value);
  endfunction

  task automatic apply_settings();
    int base_v;
    int up_v;
    int lo_v;
    int auto_v;
    int eff;
    settle();
    case ($urandom_range(0, 5))
      0: base_v = 0;
      1: base_v = SAMPLE_MAX;
      default: base_v = $urandom_range(0, 400);
    endcase
    case ($urandom_range(0, 5))
      0: up_v = 0;
      1: up_v = OFFSET_MAX;
      default: up_v = $urandom_range(1, 60);
    endcase
    case ($urandom_range(0, 5))
      0: lo_v = 0;
      1: lo_v = OFFSET_MAX;
      default: lo_v = $urandom_range(0, 60);
    endcase
    case ($urandom_range(0, 9))
      0: cur_timeout = 0;
      1: cur_timeout = 65535;
      2: cur_timeout = 1000;
      default: cur_timeout = $urandom_range(1, 40);
    endcase
    auto_v = $urandom_range(0, 1);
    put_reg(REG_BASE_THRESHOLD, with_junk(base_v, BASE_W));
    put_reg(REG_UPPER_OFFSET, with_junk(up_v, OFFSET_W));
    put_reg(REG_LOWER_OFFSET, with_junk(lo_v, OFFSET_W));
    put_reg(REG_LONG_TIMEOUT_MS, CFG_DAT_W'(cur_timeout));
    put_reg(REG_AUTO_CALIBRATE, with_junk(auto_v, 1));
    if ($urandom_range(0, 2) == 0) put_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    eff = auto_v ? CAL_BASE : base_v;
    cur_upper = eff + up_v;
    cur_lower = eff + lo_v;
  endtask

  // untouched level, press, ticks with held samples, then usually a release
  task automatic press_sequence();
    int n_ticks;
    repeat ($urandom_range(0, 2)) send_word(REQ_SAMPLE, pick(0, cur_lower - 1));
    send_word(REQ_SAMPLE, pick(cur_upper + 1, SAMPLE_MAX));
    n_ticks = (cur_timeout <= 40) ? $urandom_range(0, cur_timeout + 3) : $urandom_range(0, 6);
    repeat (n_ticks) begin
      send_word(REQ_TICK, SAMPLE_BITS_DEF'($urandom));
      if ($urandom_range(0, 3) == 0) send_word(REQ_SAMPLE, pick(cur_lower, SAMPLE_MAX));
    end
    if ($urandom_range(0, 7) != 0) send_word(REQ_SAMPLE, pick(0, cur_lower - 1));
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_SAMPLE;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BASE_THRESHOLD;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // calibration window open at reset: tick and discarded samples
    send_word(REQ_TICK, '0);
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_SAMPLE, 10'd0);
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_SAMPLE, 10'd512);

    // calibration off mid-window: fixed base, short press
    settle();
    put_reg(REG_AUTO_CALIBRATE, '0);
    put_reg(REG_BASE_THRESHOLD, 16'd50);
    cfg_valid <= 1'b0;
    send_word(REQ_SAMPLE, 10'd81);
    send_word(REQ_TICK, '1);
    send_word(REQ_TICK, '0);
    send_word(REQ_SAMPLE, 10'd64);

    // window resumes and completes with a mean of 200
    settle();
    put_reg(REG_AUTO_CALIBRATE, 16'd1);
    cfg_valid <= 1'b0;
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_SAMPLE, 10'd200);
    send_word(REQ_SAMPLE, 10'd210);
    send_word(REQ_SAMPLE, 10'd190);
    send_word(REQ_SAMPLE, 10'd205);
    send_word(REQ_SAMPLE, 10'd195);
    send_word(REQ_SAMPLE, 10'd231);
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_TICK, '0);
    send_word(REQ_SAMPLE, 10'd214);

    // thresholds beyond the sample range, zero timeout
    settle();
    put_reg(REG_AUTO_CALIBRATE, '0);
    put_reg(REG_BASE_THRESHOLD, 16'd1023);
    put_reg(REG_UPPER_OFFSET, 16'd255);
    put_reg(REG_LOWER_OFFSET, 16'd255);
    put_reg(REG_LONG_TIMEOUT_MS, '0);
    cfg_valid <= 1'b0;
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_TICK, '0);

    // zero thresholds: long press on the first tick, finger stays held
    settle();
    put_reg(REG_BASE_THRESHOLD, '0);
    put_reg(REG_UPPER_OFFSET, '0);
    put_reg(REG_LOWER_OFFSET, '0);
    cfg_valid <= 1'b0;
    send_word(REQ_SAMPLE, 10'd1);
    send_word(REQ_TICK, '0);
    send_word(REQ_SAMPLE, 10'd1);
    send_word(REQ_SAMPLE, 10'd0);

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      apply_settings();
      if (phase == 2) hold_req <= 1'b1;
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6))
            send_word(req_type_t'($urandom_range(0, 1)), SAMPLE_BITS_DEF'($urandom));
        else
          press_sequence();
      end
      phase++;
    end

    settle();
    if (failures == 0 && outstanding == 0)
      $display("touch_key_press_classifier_core test passed");
    else
      $display("touch_key_press_classifier_core test failed");
    $finish;
  end

endmodule
